// ----- rtl/arh_pkg.sv -----
// Shared types and constants for the auto-range histogram.
// Item structs for both channels, field widths and parameter defaults.
// No dependencies.
package arh_pkg;

   localparam int DATA_W           = 32;
   localparam int BIN_NUMBER_W     = 7;
   localparam int BIN_INDEX_W      = 6;
   localparam int BIN_TOTAL_W      = 11;

   localparam int DEF_MAX_SAMPLES  = 1024;
   localparam int DEF_MAX_BINS     = 64;
   localparam int DEF_FRAC_BITS    = 16;

   localparam logic [BIN_NUMBER_W-1:0] DEFAULT_BIN_NUMBER = 7'd10;
   localparam logic [BIN_TOTAL_W-1:0]  TOTAL_LIMIT        = '1;

   typedef struct packed {
      logic signed [DATA_W-1:0] sample;
      logic                     last_sample;
   } req_item_type;

   typedef struct packed {
      logic [BIN_INDEX_W-1:0]   bin_index;
      logic signed [DATA_W-1:0] bin_center;
      logic [BIN_TOTAL_W-1:0]   bin_total;
      logic                     last_bin;
   } rsp_item_type;

endpackage

// ----- rtl/arh_div.sv -----
// Shared restoring divider for the auto-range histogram, one quotient bit per cycle.
// Unsigned W-bit dividend and divisor; divisor must be nonzero.
// No package dependencies.
module arh_div #(
   parameter int W = 33
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int SW = $clog2(W + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [SW-1:0] step_ff;
   logic [W-1:0]  rem_ff;
   logic [W-1:0]  dq_ff;
   logic [W-1:0]  dvs_ff;

   logic [W:0]    rem_sh;
   logic [W+1:0]  diff;
   logic          ge;

   assign rem_sh = {rem_ff, dq_ff[W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dvs_ff};
   assign ge     = ~diff[W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= SW'(W);
            rem_ff  <= '0;
            dq_ff   <= dividend;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff  <= ge ? diff[W-1:0] : rem_sh[W-1:0];
            dq_ff   <= {dq_ff[W-2:0], ge};
            step_ff <= step_ff - SW'(1);
            if (step_ff == SW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

// ----- rtl/auto_range_histogram.sv -----
// Auto-range histogram over a data set of signed Q16.16 samples.
// Needs arh_pkg and the shared divider arh_div.
//
// Each req_ item holds one sample; the item with last_sample set closes the
// data set. Samples are written to an on-chip store of MAX_SAMPLES entries
// while the running minimum and maximum are tracked; once the store is full,
// further samples are dropped (a last_sample flag on them still closes the set).
// On the final item the block works out the bin width (max - min) / bins,
// truncated, with a zero width forced to 1.0, then bins every stored sample
// as floor((x - min) / width) clamped to bins-1, and finally sends one rsp_ item
// per bin, in bin order, with the bin centre min + floor(width * (2b + 1) / 2)
// (saturated to the signed 32-bit range), the count (saturating at 2047) and
// last_bin on the final bin. Every division runs on one shared restoring
// divider, one quotient bit per cycle over 33 bits. Each stored sample goes
// through a store read, a division start, 33 divider steps, a count read and a
// count write; each bin through a count read, an output register load and a
// wait until its item is taken. req_ready stays low from the final item until
// the last bin item is taken. The bin count register csr_ (0 acts as 1, above
// MAX_BINS acts as MAX_BINS) may only be written while the block is idle.
// After reset a clearing pass over all MAX_BINS entries zeroes the count
// memory before the first item is taken; counts are zeroed again as each bin
// item is delivered.
module auto_range_histogram
   import arh_pkg::*;
#(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int MAX_BINS    = DEF_MAX_BINS,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_item_type            req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_item_type            rsp_item,
   input  logic                    csr_write_enable,
   input  logic [BIN_NUMBER_W-1:0] csr_write_data
);

   localparam int SAMPLE_AW = $clog2(MAX_SAMPLES);
   localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
   localparam int BIN_AW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int RANGE_W   = DATA_W + 1;
   localparam int ACC_W     = RANGE_W + BIN_NUMBER_W;
   localparam int CTR_W     = DATA_W + 2;

   localparam logic [RANGE_W-1:0]   WIDTH_ONE = RANGE_W'(1) << FRAC_BITS;
   localparam logic signed [CTR_W-1:0] CTR_MAX = {3'b000, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0]    CENTER_SAT = {1'b0, {(DATA_W-1){1'b1}}};

   typedef enum logic [3:0] {
      S_CLEAR,   // zero count memory after reset
      S_IDLE,    // take samples
      S_WSTART,  // start width division
      S_WWAIT,
      S_SREAD,   // read stored sample
      S_SSTART,  // start bin division
      S_SWAIT,
      S_CREAD,   // read bin count
      S_CINC,    // write bumped count
      S_EREAD,   // read count for emit
      S_ELOAD,   // load output register
      S_EWAIT    // wait for output taken
   } state_type;

   state_type                   state_ff;
   logic [BIN_NUMBER_W-1:0]     bin_number_ff;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            idx_ff;
   logic [BIN_AW-1:0]           clr_ff;
   logic [BIN_AW-1:0]           bin_ff;
   logic [BIN_AW-1:0]           emit_ff;
   logic signed [DATA_W-1:0]    min_ff;
   logic signed [DATA_W-1:0]    max_ff;
   logic [RANGE_W-1:0]          width_ff;
   logic [ACC_W-1:0]            acc_ff;
   logic                        rsp_valid_ff;
   rsp_item_type                rsp_ff;

   // memories
   logic [DATA_W-1:0]           sample_mem [MAX_SAMPLES];
   logic [BIN_TOTAL_W-1:0]      count_mem  [MAX_BINS];
   logic [DATA_W-1:0]           smp_rd_ff;
   logic [BIN_TOTAL_W-1:0]      cnt_rd_ff;

   logic                        req_fire;
   logic                        full;
   logic [BIN_NUMBER_W-1:0]     bins_act;
   logic [BIN_NUMBER_W-1:0]     bins_m1;
   logic [RANGE_W-1:0]          range;
   logic [RANGE_W-1:0]          offset;
   logic                        div_start;
   logic [RANGE_W-1:0]          div_dividend;
   logic [RANGE_W-1:0]          div_divisor;
   logic                        div_done;
   logic [RANGE_W-1:0]          div_q;
   logic [BIN_NUMBER_W-1:0]     bin_sel;
   logic [ACC_W-2:0]            half;
   logic [DATA_W-1:0]           half_sat;
   logic signed [CTR_W-1:0]     ctr;
   logic [DATA_W-1:0]           centre;
   logic                        is_last_bin;
   logic [CNT_W-1:0]            idx_next;
   logic                        cnt_we;
   logic [BIN_AW-1:0]           cnt_waddr;
   logic [BIN_TOTAL_W-1:0]      cnt_wdata;
   logic [BIN_AW-1:0]           cnt_raddr;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign full      = (count_ff == CNT_W'(MAX_SAMPLES));

   // clamp bin count register to 1..MAX_BINS
   always_comb begin
      bins_act = bin_number_ff;
      if (bin_number_ff == '0) begin
         bins_act = BIN_NUMBER_W'(1);
      end else if (bin_number_ff > BIN_NUMBER_W'(MAX_BINS)) begin
         bins_act = BIN_NUMBER_W'(MAX_BINS);
      end
   end
   assign bins_m1 = bins_act - BIN_NUMBER_W'(1);

   // range and offset are exact, non-negative, 33 bits
   assign range  = {max_ff[DATA_W-1], max_ff} - {min_ff[DATA_W-1], min_ff};
   assign offset = {smp_rd_ff[DATA_W-1], smp_rd_ff} - {min_ff[DATA_W-1], min_ff};

   assign div_start    = (state_ff == S_WSTART) || (state_ff == S_SSTART);
   assign div_dividend = (state_ff == S_WSTART) ? range : offset;
   assign div_divisor  = (state_ff == S_WSTART) ? RANGE_W'(bins_act) : width_ff;

   arh_div #(
      .W(RANGE_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign bin_sel = (div_q > RANGE_W'(bins_m1)) ? bins_m1 : div_q[BIN_NUMBER_W-1:0];

   // centre: acc_ff holds width * (2b + 1)
   assign half     = acc_ff[ACC_W-1:1];
   assign half_sat = (|half[ACC_W-2:DATA_W]) ? '1 : half[DATA_W-1:0];
   assign ctr      = $signed({{2{min_ff[DATA_W-1]}}, min_ff}) + $signed({2'b00, half_sat});
   assign centre   = (ctr > CTR_MAX) ? CENTER_SAT : ctr[DATA_W-1:0];

   assign is_last_bin = (BIN_NUMBER_W'(emit_ff) == bins_m1);
   assign idx_next    = idx_ff + CNT_W'(1);

   // count memory write port
   always_comb begin
      cnt_we    = 1'b0;
      cnt_waddr = emit_ff;
      cnt_wdata = '0;
      if (state_ff == S_CLEAR) begin
         cnt_we    = 1'b1;
         cnt_waddr = clr_ff;
      end else if (state_ff == S_CINC) begin
         cnt_we    = 1'b1;
         cnt_waddr = bin_ff;
         cnt_wdata = (cnt_rd_ff == TOTAL_LIMIT) ? cnt_rd_ff
                                                : cnt_rd_ff + BIN_TOTAL_W'(1);
      end else if ((state_ff == S_EWAIT) && rsp_ready) begin
         cnt_we    = 1'b1;
      end
   end
   assign cnt_raddr = (state_ff == S_CREAD) ? bin_ff : emit_ff;

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= count_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (req_fire && !full) begin
         sample_mem[count_ff[SAMPLE_AW-1:0]] <= req_item.sample;
      end
      smp_rd_ff <= sample_mem[idx_ff[SAMPLE_AW-1:0]];
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_number_ff <= DEFAULT_BIN_NUMBER;
      end else if (csr_write_enable) begin
         bin_number_ff <= csr_write_data;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + BIN_AW'(1);
               if (clr_ff == BIN_AW'(MAX_BINS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  if (!full) begin
                     count_ff <= count_ff + CNT_W'(1);
                     if (count_ff == '0) begin
                        min_ff <= req_item.sample;
                        max_ff <= req_item.sample;
                     end else begin
                        if (req_item.sample < min_ff) min_ff <= req_item.sample;
                        if (req_item.sample > max_ff) max_ff <= req_item.sample;
                     end
                  end
                  if (req_item.last_sample) begin
                     state_ff <= S_WSTART;
                  end
               end
            end
            S_WSTART: begin
               state_ff <= S_WWAIT;
            end
            S_WWAIT: begin
               if (div_done) begin
                  width_ff <= (div_q == '0) ? WIDTH_ONE : div_q;
                  idx_ff   <= '0;
                  state_ff <= S_SREAD;
               end
            end
            S_SREAD: begin
               state_ff <= S_SSTART;
            end
            S_SSTART: begin
               state_ff <= S_SWAIT;
            end
            S_SWAIT: begin
               if (div_done) begin
                  bin_ff   <= bin_sel[BIN_AW-1:0];
                  state_ff <= S_CREAD;
               end
            end
            S_CREAD: begin
               state_ff <= S_CINC;
            end
            S_CINC: begin
               idx_ff <= idx_next;
               if (idx_next == count_ff) begin
                  emit_ff  <= '0;
                  acc_ff   <= ACC_W'(width_ff);
                  state_ff <= S_EREAD;
               end else begin
                  state_ff <= S_SREAD;
               end
            end
            S_EREAD: begin
               state_ff <= S_ELOAD;
            end
            S_ELOAD: begin
               rsp_ff.bin_index  <= BIN_INDEX_W'(emit_ff);
               rsp_ff.bin_center <= centre;
               rsp_ff.bin_total  <= cnt_rd_ff;
               rsp_ff.last_bin   <= is_last_bin;
               rsp_valid_ff      <= 1'b1;
               state_ff          <= S_EWAIT;
            end
            S_EWAIT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  emit_ff      <= emit_ff + BIN_AW'(1);
                  acc_ff       <= acc_ff + ACC_W'({width_ff, 1'b0});
                  if (rsp_ff.last_bin) begin
                     count_ff <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_EREAD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- rtl/arh_checker.sv -----
// Port-level checks for auto_range_histogram, attached by bind.
// Needs arh_pkg for the item structs.
module arh_checker
   import arh_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_item_type req_item,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_item
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("rsp item changed while stalled");

   // no input is taken while bins are being sent
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready high during emit");

   // a non-final sample gives no result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_item.last_sample |=> !rsp_valid)
      else $error("result after non-final sample");

   // emit continues until the last bin is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_item.last_bin |=> !req_ready)
      else $error("block went idle before last bin");

endmodule

bind auto_range_histogram arh_checker u_arh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

// ----- test/bin_report_checker.sv -----
`timescale 1ns / 1ps
// Checker for auto_range_histogram: watches req_, rsp_ and csr_ traffic,
// predicts every bin item and compares it field by field. Needs arh_pkg.
module bin_report_checker
   import arh_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  req_item_type            req_item,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rsp_item_type            rsp_item,
   input  logic                    csr_write_enable,
   input  logic [BIN_NUMBER_W-1:0] csr_write_data,
   output int                      failures,
   output int                      outstanding,
   output int                      results_seen,
   output int                      sets_seen
);

   logic signed [DATA_W-1:0] held_samples [DEF_MAX_SAMPLES];
   int                       held_count;
   longint                   set_min, set_max;
   logic [BIN_NUMBER_W-1:0]  bin_setting;
   rsp_item_type             awaited_bins [$];

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
      failures++;
   endtask

   // Close the data set: bin every held sample, queue one item per bin.
   task automatic predict_bins();
      int           nbins;
      longint       width, slot, half, centre;
      int           tally [DEF_MAX_BINS];
      rsp_item_type bin_item;
      nbins = (bin_setting == 0) ? 1 :
              (bin_setting > DEF_MAX_BINS) ? DEF_MAX_BINS : int'(bin_setting);
      width = (set_max - set_min) / longint'(nbins);
      if (width == 0)
         width = longint'(1) << DEF_FRAC_BITS;   // zero width (flat or tiny range): forced to 1.0
      for (int b = 0; b < DEF_MAX_BINS; b++)
         tally[b] = 0;
      for (int i = 0; i < held_count; i++) begin
         slot = (longint'(held_samples[i]) - set_min) / width;
         if (slot > nbins - 1)
            slot = nbins - 1;
         if (tally[slot] < int'(TOTAL_LIMIT))
            tally[slot]++;
      end
      for (int b = 0; b < nbins; b++) begin
         half = (width * (2 * b + 1)) >>> 1;
         if (half > longint'(32'hFFFF_FFFF))
            half = longint'(32'hFFFF_FFFF);
         centre = set_min + half;
         if (centre > longint'(32'sh7FFF_FFFF))
            centre = longint'(32'sh7FFF_FFFF);   // centre saturates near the top
         bin_item.bin_index  = b[BIN_INDEX_W-1:0];
         bin_item.bin_center = centre[DATA_W-1:0];
         bin_item.bin_total  = tally[b][BIN_TOTAL_W-1:0];
         bin_item.last_bin   = (b == nbins - 1);
         awaited_bins.insert(awaited_bins.size(), bin_item);
      end
      held_count = 0;
      sets_seen++;
   endtask

   task automatic absorb_sample(input req_item_type item);
      longint x;
      x = longint'(item.sample);
      // a full store drops the sample; min and max stay as they are
      if (held_count < DEF_MAX_SAMPLES) begin
         if (held_count == 0) begin
            set_min = x;
            set_max = x;
         end else begin
            if (x < set_min) set_min = x;
            if (x > set_max) set_max = x;
         end
         held_samples[held_count] = item.sample;
         held_count++;
      end
      if (item.last_sample)
         predict_bins();
   endtask

   task automatic check_bin(input rsp_item_type got);
      rsp_item_type want;
      results_seen++;
      if (awaited_bins.size() == 0) begin
         report_mismatch("bin item with none pending, bin_index", got.bin_index, -1);
      end else begin
         want = awaited_bins.pop_front();
         if (got.bin_index !== want.bin_index)
            report_mismatch("bin_index", got.bin_index, want.bin_index);
         if (got.bin_center !== want.bin_center)
            report_mismatch("bin_center", longint'(got.bin_center),
                            longint'(want.bin_center));
         if (got.bin_total !== want.bin_total)
            report_mismatch("bin_total", got.bin_total, want.bin_total);
         if (got.last_bin !== want.last_bin)
            report_mismatch("last_bin", got.last_bin, want.last_bin);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bin_setting  = DEFAULT_BIN_NUMBER;
         held_count   = 0;
         set_min      = 0;
         set_max      = 0;
         failures     = 0;
         results_seen = 0;
         sets_seen    = 0;
         awaited_bins.delete();
      end else begin
         if (csr_write_enable)
            bin_setting = csr_write_data;
         if (rsp_valid && rsp_ready)
            check_bin(rsp_item);
         if (req_valid && req_ready)
            absorb_sample(req_item);
      end
      outstanding <= awaited_bins.size();
   end

endmodule

// ----- test/auto_range_histogram_test.sv -----
`timescale 1ns / 1ps
// Top of the auto_range_histogram bench: clock, reset, stimulus and verdict.
// Needs arh_pkg, the block itself and bin_report_checker.
module auto_range_histogram_test;
   import arh_pkg::*;

   localparam int CYCLE_LIMIT   = 3000000;
   localparam int RANDOM_ITEMS  = 255;
   localparam int MAX_GAP       = 18;
   // idle time after the last bin item before touching csr_
   localparam int SETTLE_CYCLES = 16;

   // how the samples of one random data set are spread
   typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_FLAT, SPREAD_WIDE} spread_type;

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_ready;
   req_item_type            req_item         = '0;
   logic                    rsp_valid;
   logic                    rsp_ready        = 1'b0;
   rsp_item_type            rsp_item;
   logic                    csr_write_enable = 1'b0;
   logic [BIN_NUMBER_W-1:0] csr_write_data   = '0;

   int failures, outstanding, results_seen, sets_seen;
   int cycle_count  = 0;
   int random_items = 0;
   bit quiet_req    = 1'b0;   // no gaps between req_ items while set
   bit quiet_rsp    = 1'b0;   // rsp_ready never dropped while set
   logic signed [DATA_W-1:0] pending_set [$];

   auto_range_histogram dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   bin_report_checker bin_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .outstanding      (outstanding),
      .results_seen     (results_seen),
      .sets_seen        (sets_seen)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop: a hung handshake or lost bin item ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bin items still pending",
                  cycle_count, outstanding);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result side: per item, hold ready low for a random gap, then take it.
   // Ready stays high across back-to-back items when the gap is zero.
   initial begin : rsp_sink
      int gap;
      forever begin
         gap = quiet_rsp ? 0 : $urandom_range(0, MAX_GAP);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   function automatic logic signed [DATA_W-1:0] draw_sample(
      input spread_type shape, input logic signed [DATA_W-1:0] base);
      case (shape)
         SPREAD_FULL:   return $urandom;
         SPREAD_NARROW: return base + $urandom_range(0, 255);
         SPREAD_FLAT:   return base;
         default:       return base + $urandom_range(0, 200 << 16) - (100 << 16);
      endcase
   endfunction

   // Append one sample to the data set being built.
   function automatic void queue_sample(input logic signed [DATA_W-1:0] value);
      pending_set.insert(pending_set.size(), value);
   endfunction

   // One req_ item; valid stays up afterwards so a zero gap streams the next.
   task automatic send_sample(input logic signed [DATA_W-1:0] value, input logic closes);
      int gap;
      gap = quiet_req ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{sample: value, last_sample: closes};
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Send pending_set as one data set, last_sample on its final item.
   task automatic send_set();
      foreach (pending_set[i])
         send_sample(pending_set[i], i == pending_set.size() - 1);
      pending_set.delete();
   endtask

   // Wait until every predicted bin item has been taken and the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_bins(input logic [BIN_NUMBER_W-1:0] setting);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= setting;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [BIN_NUMBER_W-1:0]  setting;
      logic signed [DATA_W-1:0] base;
      spread_type               shape;
      int                       len;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // let the count-memory clearing pass finish before any csr_ write
      repeat (DEF_MAX_BINS + SETTLE_CYCLES) @(posedge clock);

      // ---- directed sets ----
      // default of 10 bins, single zero sample: zero range, width 1.0
      queue_sample(32'sd0);
      send_set();

      // 0 acts as one bin; the two extremes give the widest range
      write_bins(7'd0);
      queue_sample(32'sh8000_0000);
      queue_sample(32'sh7FFF_FFFF);
      send_set();

      // all ones acts as 64 bins; lone top value saturates the centres
      write_bins(7'h7F);
      queue_sample(32'sh7FFF_FFFF);
      send_set();
      queue_sample(-32'sd327680);    // -5.0
      queue_sample(32'sd212992);     // 3.25
      queue_sample(32'sd0);
      queue_sample(32'sd458752);     // 7.0, twice
      queue_sample(32'sd458752);
      queue_sample(32'sh8000_0000);
      send_set();

      // 64 bins over a tiny range near the top: width forced to 1.0, saturation
      write_bins(7'd64);
      queue_sample(32'sh7FFF_FFFF);
      queue_sample(32'sh7FFF_FFF5);
      send_set();

      write_bins(7'd1);
      queue_sample(32'sd1);
      queue_sample(32'sd2);
      queue_sample(32'sd3);
      send_set();

      // 3 bins of width 3.0: samples on and just under the edges, max clamped
      write_bins(7'd3);
      queue_sample(32'sd0);
      queue_sample(32'sd196607);     // just under 3.0
      queue_sample(32'sd196608);     // 3.0
      queue_sample(32'sd393215);     // just under 6.0
      queue_sample(32'sd393216);     // 6.0
      queue_sample(32'sd589824);     // 9.0, top edge
      send_set();

      // ---- random phases: new bin count, then a few data sets ----
      while (random_items < RANDOM_ITEMS) begin
         quiet_req = ($urandom_range(0, 3) == 0);
         quiet_rsp = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 7))
            0:       setting = 7'd0;
            1:       setting = 7'(DEF_MAX_BINS);
            2:       setting = 7'h7F;
            3:       setting = 7'($urandom_range(0, 127));
            default: setting = 7'($urandom_range(1, 12));
         endcase
         write_bins(setting);
         repeat ($urandom_range(1, 4)) begin
            shape = spread_type'($urandom_range(0, 3));
            base  = $urandom;
            len   = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
                                                : $urandom_range(1, 10);
            repeat (len) queue_sample(draw_sample(shape, base));
            random_items += len;
            send_set();
         end
      end

      drain();
      repeat (4 * SETTLE_CYCLES) @(posedge clock);

      $display("ran %0d data sets (%0d random samples), %0d bin items checked,",
               sets_seen, random_items, results_seen);
      $display("bin settings 0..127 incl. extremes, random spreads and stalls");
      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", failures);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
